FILE: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros, compiled out with NO_ASSERTIONS
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// condition must hold at every edge outside reset
`define ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (cond)) \
        else $error(msg);

// trigger implies condition in the next cycle
`define ASSERT_NEXT(label, clk, rst_n, trig, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (trig) |=> (cond)) \
        else $error(msg);

`else

`define ASSERT_ALWAYS(label, clk, rst_n, cond, msg)
`define ASSERT_NEXT(label, clk, rst_n, trig, cond, msg)

`endif

`endif

FILE: rtl/aabb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aabb_pkg
// Widths, types and register codes of the bounding box transform
// ----------------------------------------------------------------------------
package aabb_pkg;

    // number formats
    localparam int COORD_WIDTH  = 32;
    localparam int COEF_WIDTH   = 16;
    localparam int FRAC_BITS    = COEF_WIDTH - 2;
    localparam int ROW_WIDTH    = 3 * COEF_WIDTH;
    localparam int PROD_WIDTH   = COORD_WIDTH + COEF_WIDTH;
    localparam int SUM_WIDTH    = PROD_WIDTH + 2;
    localparam int SCALED_WIDTH = SUM_WIDTH - FRAC_BITS;
    localparam int EXT_WIDTH    = SCALED_WIDTH + 1;
    localparam int NUM_AXES     = 3;

    // streaming and register port widths
    localparam int BOX_WIDTH      = 2 * NUM_AXES * COORD_WIDTH;
    localparam int TDATA_WIDTH    = ((BOX_WIDTH + 7) / 8) * 8;
    localparam int CFG_DATA_WIDTH = (ROW_WIDTH > COORD_WIDTH) ? ROW_WIDTH : COORD_WIDTH;
    localparam int CFG_IDX_WIDTH  = 3;

    typedef logic signed [COORD_WIDTH-1:0]  coord_t;
    typedef logic signed [COEF_WIDTH-1:0]   coef_t;
    typedef logic signed [PROD_WIDTH-1:0]   prod_t;
    typedef logic signed [SUM_WIDTH-1:0]    sum_t;
    typedef logic signed [SCALED_WIDTH-1:0] scaled_t;
    typedef logic signed [EXT_WIDTH-1:0]    ext_t;
    typedef logic [ROW_WIDTH-1:0]           row_t;

    // rounding constant for the upper bound (ceiling shift)
    localparam sum_t FRAC_MASK = sum_t'((64'd1 << FRAC_BITS) - 64'd1);

    // identity matrix rows after reset
    localparam row_t ROW0_RESET = row_t'(1) << FRAC_BITS;
    localparam row_t ROW1_RESET = row_t'(1) << (FRAC_BITS + COEF_WIDTH);
    localparam row_t ROW2_RESET = row_t'(1) << (FRAC_BITS + 2 * COEF_WIDTH);

    // register indexes
    typedef enum logic [CFG_IDX_WIDTH-1:0] {
        REG_ROW0    = 3'd0,
        REG_ROW1    = 3'd1,
        REG_ROW2    = 3'd2,
        REG_SHIFT_X = 3'd3,
        REG_SHIFT_Y = 3'd4,
        REG_SHIFT_Z = 3'd5
    } cfg_reg_t;

    // one output axis: both bounds and the clamp flag
    typedef struct packed {
        coord_t lo;
        coord_t hi;
        logic   sat;
    } axis_result_t;

endpackage

FILE: rtl/aabb_affine_transform.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aabb_affine_transform
// Tight axis-aligned box of the affine image of a box, Q16.16 coordinates
// ----------------------------------------------------------------------------
// Usage:
//   s_tdata carries one box (min x,y,z then max x,y,z, 32 bits each, min x
//   lowest); m_tdata returns the transformed box in the same layout and
//   m_tuser flags that some bound was clamped to the 32-bit range.
//   The cfg channel writes the three coefficient rows (index 0..2, Q2.14,
//   column 0 lowest) and the translations (index 3..5); other indexes are
//   dropped. cfg_ready is always high; write only while no box is in flight.
//   A request passes through operand order, products, sums, rounding with
//   translation and saturation, each registered. Without a stall one box is
//   taken every cycle; the multiplier stage (18 multipliers, 32x16) sets the
//   clock. When the receiver stalls, the whole pipeline holds and s_tready
//   drops in the same cycle, so no request is lost or repeated.
//   Reset clears all valid bits and loads the identity matrix with zero
//   translation.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module aabb_affine_transform (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    // in_min_x, in_min_y, in_min_z, in_max_x, in_max_y, in_max_z (low to high)
    input  logic [aabb_pkg::TDATA_WIDTH-1:0]      s_tdata,
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    // out_min_x, out_min_y, out_min_z, out_max_x, out_max_y, out_max_z
    output logic [aabb_pkg::TDATA_WIDTH-1:0]      m_tdata,
    // saturated
    output logic                                  m_tuser,
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [aabb_pkg::CFG_IDX_WIDTH-1:0]    cfg_index,
    input  logic [aabb_pkg::CFG_DATA_WIDTH-1:0]   cfg_data
);

    localparam int STAGES = 5;

    logic                   advance;
    logic [STAGES-1:0]      stage_valid_reg, stage_valid_next;
    aabb_pkg::row_t         row_reg   [aabb_pkg::NUM_AXES];
    aabb_pkg::coord_t       shift_reg [aabb_pkg::NUM_AXES];
    aabb_pkg::coord_t       box_min   [aabb_pkg::NUM_AXES];
    aabb_pkg::coord_t       box_max   [aabb_pkg::NUM_AXES];
    aabb_pkg::coord_t       small_reg [aabb_pkg::NUM_AXES];
    aabb_pkg::coord_t       large_reg [aabb_pkg::NUM_AXES];
    aabb_pkg::axis_result_t axis_res  [aabb_pkg::NUM_AXES];

    // global stall: everything moves unless the output holds an unread result
    assign advance   = ~stage_valid_reg[STAGES-1] | m_tready;
    assign s_tready  = advance;
    assign m_tvalid  = stage_valid_reg[STAGES-1];
    assign cfg_ready = 1'b1;

    // valid bits travel with the data
    assign stage_valid_next = {stage_valid_reg[STAGES-2:0], s_tvalid};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stage_valid_reg <= '0;
        end else if (advance) begin
            stage_valid_reg <= stage_valid_next;
        end
    end

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_reg[0]   <= aabb_pkg::ROW0_RESET;
            row_reg[1]   <= aabb_pkg::ROW1_RESET;
            row_reg[2]   <= aabb_pkg::ROW2_RESET;
            shift_reg[0] <= '0;
            shift_reg[1] <= '0;
            shift_reg[2] <= '0;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                aabb_pkg::REG_ROW0:    row_reg[0]   <= cfg_data[aabb_pkg::ROW_WIDTH-1:0];
                aabb_pkg::REG_ROW1:    row_reg[1]   <= cfg_data[aabb_pkg::ROW_WIDTH-1:0];
                aabb_pkg::REG_ROW2:    row_reg[2]   <= cfg_data[aabb_pkg::ROW_WIDTH-1:0];
                aabb_pkg::REG_SHIFT_X: shift_reg[0] <= cfg_data[aabb_pkg::COORD_WIDTH-1:0];
                aabb_pkg::REG_SHIFT_Y: shift_reg[1] <= cfg_data[aabb_pkg::COORD_WIDTH-1:0];
                aabb_pkg::REG_SHIFT_Z: shift_reg[2] <= cfg_data[aabb_pkg::COORD_WIDTH-1:0];
                default: ;
            endcase
        end
    end

    // unpack the request and order each pair of bounds
    always_comb begin
        for (int j = 0; j < aabb_pkg::NUM_AXES; j++) begin
            box_min[j] = s_tdata[j*aabb_pkg::COORD_WIDTH +: aabb_pkg::COORD_WIDTH];
            box_max[j] = s_tdata[(j+aabb_pkg::NUM_AXES)*aabb_pkg::COORD_WIDTH +:
                                 aabb_pkg::COORD_WIDTH];
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            for (int j = 0; j < aabb_pkg::NUM_AXES; j++) begin
                small_reg[j] <= (box_min[j] < box_max[j]) ? box_min[j] : box_max[j];
                large_reg[j] <= (box_min[j] < box_max[j]) ? box_max[j] : box_min[j];
            end
        end
    end

    // one arithmetic pipeline per output axis
    for (genvar i = 0; i < aabb_pkg::NUM_AXES; i++) begin : g_axis
        aabb_axis u_axis (
            .aclk     (aclk),
            .advance  (advance),
            .small_in (small_reg),
            .large_in (large_reg),
            .row      (row_reg[i]),
            .shift    (shift_reg[i]),
            .result   (axis_res[i])
        );
    end

    // pack the result
    always_comb begin
        m_tdata = '0;
        for (int i = 0; i < aabb_pkg::NUM_AXES; i++) begin
            m_tdata[i*aabb_pkg::COORD_WIDTH +: aabb_pkg::COORD_WIDTH] = axis_res[i].lo;
            m_tdata[(i+aabb_pkg::NUM_AXES)*aabb_pkg::COORD_WIDTH +: aabb_pkg::COORD_WIDTH] =
                axis_res[i].hi;
        end
    end

    assign m_tuser = axis_res[0].sat | axis_res[1].sat | axis_res[2].sat;

    // checks
    `ASSERT_NEXT(a_accept_enters, aclk, aresetn, s_tvalid && s_tready, stage_valid_reg[0], "accepted request did not enter the pipeline")
    `ASSERT_NEXT(a_stall_holds, aclk, aresetn, !advance, $stable(stage_valid_reg), "valid bits moved during a stall")
    `ASSERT_ALWAYS(a_box_ordered, aclk, aresetn, !m_tvalid || ((axis_res[0].lo <= axis_res[0].hi) && (axis_res[1].lo <= axis_res[1].hi) && (axis_res[2].lo <= axis_res[2].hi)), "result lower bound above upper bound")

endmodule

FILE: rtl/aabb_axis.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aabb_axis
// Four-stage pipeline for one output axis: products, sums, rounding plus
// translation, saturation
// ----------------------------------------------------------------------------
module aabb_axis (
    input  logic                   aclk,
    input  logic                   advance,
    input  aabb_pkg::coord_t       small_in [aabb_pkg::NUM_AXES],
    input  aabb_pkg::coord_t       large_in [aabb_pkg::NUM_AXES],
    input  aabb_pkg::row_t         row,
    input  aabb_pkg::coord_t       shift,
    output aabb_pkg::axis_result_t result
);

    aabb_pkg::coef_t   coef     [aabb_pkg::NUM_AXES];
    aabb_pkg::coord_t  lo_op    [aabb_pkg::NUM_AXES];
    aabb_pkg::coord_t  hi_op    [aabb_pkg::NUM_AXES];
    aabb_pkg::prod_t   prod_lo_next [aabb_pkg::NUM_AXES];
    aabb_pkg::prod_t   prod_hi_next [aabb_pkg::NUM_AXES];
    aabb_pkg::prod_t   prod_lo_reg  [aabb_pkg::NUM_AXES];
    aabb_pkg::prod_t   prod_hi_reg  [aabb_pkg::NUM_AXES];
    aabb_pkg::sum_t    sum_lo_next, sum_hi_next;
    aabb_pkg::sum_t    sum_lo_reg, sum_hi_reg;
    aabb_pkg::scaled_t scaled_lo, scaled_hi;
    aabb_pkg::ext_t    ext_lo_next, ext_hi_next;
    aabb_pkg::ext_t    ext_lo_reg, ext_hi_reg;
    logic              ovf_lo, ovf_hi;
    aabb_pkg::axis_result_t result_next, result_reg;

    // operand choice by coefficient sign, then the products
    always_comb begin
        for (int j = 0; j < aabb_pkg::NUM_AXES; j++) begin
            coef[j]  = aabb_pkg::coef_t'(row[j*aabb_pkg::COEF_WIDTH +: aabb_pkg::COEF_WIDTH]);
            lo_op[j] = coef[j][aabb_pkg::COEF_WIDTH-1] ? large_in[j] : small_in[j];
            hi_op[j] = coef[j][aabb_pkg::COEF_WIDTH-1] ? small_in[j] : large_in[j];
            prod_lo_next[j] = aabb_pkg::prod_t'(lo_op[j]) * aabb_pkg::prod_t'(coef[j]);
            prod_hi_next[j] = aabb_pkg::prod_t'(hi_op[j]) * aabb_pkg::prod_t'(coef[j]);
        end
    end

    // exact sums of the three products
    assign sum_lo_next = aabb_pkg::sum_t'(prod_lo_reg[0]) + aabb_pkg::sum_t'(prod_lo_reg[1])
                       + aabb_pkg::sum_t'(prod_lo_reg[2]);
    assign sum_hi_next = aabb_pkg::sum_t'(prod_hi_reg[0]) + aabb_pkg::sum_t'(prod_hi_reg[1])
                       + aabb_pkg::sum_t'(prod_hi_reg[2]);

    // floor for the lower bound, ceiling for the upper, then translation
    assign scaled_lo   = aabb_pkg::scaled_t'(sum_lo_reg >>> aabb_pkg::FRAC_BITS);
    assign scaled_hi   = aabb_pkg::scaled_t'((sum_hi_reg + aabb_pkg::FRAC_MASK)
                                             >>> aabb_pkg::FRAC_BITS);
    assign ext_lo_next = aabb_pkg::ext_t'(scaled_lo) + aabb_pkg::ext_t'(shift);
    assign ext_hi_next = aabb_pkg::ext_t'(scaled_hi) + aabb_pkg::ext_t'(shift);

    // clamp to the coordinate range when the top bits disagree
    assign ovf_lo = ~((&ext_lo_reg[aabb_pkg::EXT_WIDTH-1:aabb_pkg::COORD_WIDTH-1]) |
                      ~(|ext_lo_reg[aabb_pkg::EXT_WIDTH-1:aabb_pkg::COORD_WIDTH-1]));
    assign ovf_hi = ~((&ext_hi_reg[aabb_pkg::EXT_WIDTH-1:aabb_pkg::COORD_WIDTH-1]) |
                      ~(|ext_hi_reg[aabb_pkg::EXT_WIDTH-1:aabb_pkg::COORD_WIDTH-1]));

    always_comb begin
        result_next.lo  = ext_lo_reg[aabb_pkg::COORD_WIDTH-1:0];
        result_next.hi  = ext_hi_reg[aabb_pkg::COORD_WIDTH-1:0];
        result_next.sat = ovf_lo | ovf_hi;
        if (ovf_lo) begin
            result_next.lo = {ext_lo_reg[aabb_pkg::EXT_WIDTH-1],
                              {(aabb_pkg::COORD_WIDTH-1){~ext_lo_reg[aabb_pkg::EXT_WIDTH-1]}}};
        end
        if (ovf_hi) begin
            result_next.hi = {ext_hi_reg[aabb_pkg::EXT_WIDTH-1],
                              {(aabb_pkg::COORD_WIDTH-1){~ext_hi_reg[aabb_pkg::EXT_WIDTH-1]}}};
        end
    end

    // pipeline registers, all held while stalled
    always_ff @(posedge aclk) begin
        if (advance) begin
            prod_lo_reg <= prod_lo_next;
            prod_hi_reg <= prod_hi_next;
            sum_lo_reg  <= sum_lo_next;
            sum_hi_reg  <= sum_hi_next;
            ext_lo_reg  <= ext_lo_next;
            ext_hi_reg  <= ext_hi_next;
            result_reg  <= result_next;
        end
    end

    assign result = result_reg;

endmodule
